### hdl/matrix_power_defines.svh
// ----------------------------------------------------------------------------
// matrix_power assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef MATRIX_POWER_DEFINES_SVH
`define MATRIX_POWER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MP_ASSERT_IMPL(label, ante, cons, msg)
`define MP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hdl/mp_pkg.sv
// ----------------------------------------------------------------------------
// mp_pkg
// shared widths, codes and types of the matrix power block
// ----------------------------------------------------------------------------
package mp_pkg;

  localparam int DATA_W          = 32;
  localparam int EXP_W           = 8;
  localparam int IDX_PORT_W      = 2;
  localparam int S_TDATA_W       = 48;
  localparam int M_TDATA_W       = 40;
  localparam int DEF_MATRIX_SIZE = 4;

  // item kinds carried on s_tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // q2.30 constants
  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh4000_0000;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // sequencer controls for the multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctl_t;

endpackage

### hdl/matrix_power.sv
// ----------------------------------------------------------------------------
// matrix_power
// raises a stored square q2.30 matrix to an integer power and streams it out
// ----------------------------------------------------------------------------
// Input beats on the s_ group: s_tuser 0 loads one element (row, column,
// value); s_tuser 1 starts a run with the exponent in s_tdata. A run
// emits MATRIX_SIZE^2 beats on the m_ group, row by row, m_tlast on the
// final one. Exponent 0 gives the identity, exponent 1 the loaded matrix.
// Exponent >= 2 takes (exponent-1) multiply passes, in which every product
// term goes through the one multiply-accumulate unit in read, multiply
// and accumulate states, and every element ends in a write state.
// Emission then steps through a memory read and an output load per beat.
// s_tready is high only while the sequencer is idle; the output register
// keeps the last beat of a run while new load beats are taken. A stalled
// m_tready holds the output beat and pauses emission. rst clears the
// sequencer and the output valid; matrix contents are not cleared, and an
// element never loaded reads as unknown.
// ----------------------------------------------------------------------------
`include "matrix_power_defines.svh"

module matrix_power #(
  parameter int MATRIX_SIZE = mp_pkg::DEF_MATRIX_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row_index[1:0], col_index[3:2], elem_value[35:4], exponent[43:36], zero fill
  input  logic [mp_pkg::S_TDATA_W-1:0]    s_tdata,
  // mode
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_row[1:0], out_col[3:2], out_value[35:4], zero fill
  output logic [mp_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                            m_tlast
);
  import mp_pkg::*;

  localparam int IDX_W  = $clog2(MATRIX_SIZE);
  localparam int ADDR_W = $clog2(MATRIX_SIZE * MATRIX_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MATRIX_SIZE - 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRD  = 3'd1;
  localparam logic [2:0] S_MMUL = 3'd2;
  localparam logic [2:0] S_MACC = 3'd3;
  localparam logic [2:0] S_MWR  = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_ELD  = 3'd6;

  logic [2:0]       state, state_next;
  logic [EXP_W-1:0] power, power_next;
  logic [EXP_W-1:0] pass, pass_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] k, k_next;

  logic                     out_valid;
  logic [IDX_PORT_W-1:0]    out_row;
  logic [IDX_PORT_W-1:0]    out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;
  logic                     out_load;

  logic [IDX_PORT_W-1:0]    in_row;
  logic [IDX_PORT_W-1:0]    in_col;
  logic signed [DATA_W-1:0] in_value;
  logic [EXP_W-1:0]         in_exp;
  logic                     in_beat;
  logic                     in_range;

  logic [EXP_W-1:0]  power_m1;
  logic              emitting;
  logic              elem_last;
  logic [ADDR_W-1:0] addr_ik;
  logic [ADDR_W-1:0] addr_kj;
  logic [ADDR_W-1:0] addr_ij;

  logic                     base_we;
  logic [ADDR_W-1:0]        base_waddr;
  logic signed [DATA_W-1:0] base_rdata_a;
  logic signed [DATA_W-1:0] base_rdata_b;
  logic                     prod_we;
  logic [ADDR_W:0]          prod_waddr;
  logic [ADDR_W:0]          prod_raddr;
  logic signed [DATA_W-1:0] prod_rdata;

  mac_ctl_t                 mac_ctl;
  logic signed [DATA_W-1:0] mac_a;
  logic signed [DATA_W-1:0] mac_acc;
  logic signed [DATA_W-1:0] emit_value;

  // input field unpacking
  assign in_row   = s_tdata[1:0];
  assign in_col   = s_tdata[3:2];
  assign in_value = s_tdata[35:4];
  assign in_exp   = s_tdata[43:36];
  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign in_range = (32'(in_row) < 32'(MATRIX_SIZE)) && (32'(in_col) < 32'(MATRIX_SIZE));

  // element addresses, row major
  assign addr_ik = ADDR_W'(32'(i) * 32'(MATRIX_SIZE) + 32'(k));
  assign addr_kj = ADDR_W'(32'(k) * 32'(MATRIX_SIZE) + 32'(j));
  assign addr_ij = ADDR_W'(32'(i) * 32'(MATRIX_SIZE) + 32'(j));

  assign power_m1  = power - EXP_W'(1);
  assign emitting  = (state == S_ERD) || (state == S_ELD);
  assign elem_last = (i == IDX_LAST) && (j == IDX_LAST);

  // memory ports
  assign base_we    = in_beat && (s_tuser == MODE_LOAD) && in_range;
  assign base_waddr = ADDR_W'(32'(in_row) * 32'(MATRIX_SIZE) + 32'(in_col));
  assign prod_we    = (state == S_MWR);
  assign prod_waddr = {pass[0], addr_ij};
  assign prod_raddr = emitting ? {power[0], addr_ij} : {~pass[0], addr_ik};

  mp_store #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_store (
    .clk          (clk),
    .base_we      (base_we),
    .base_waddr   (base_waddr),
    .base_wdata   (in_value),
    .base_raddr_a (emitting ? addr_ij : addr_ik),
    .base_raddr_b (addr_kj),
    .base_rdata_a (base_rdata_a),
    .base_rdata_b (base_rdata_b),
    .prod_we      (prod_we),
    .prod_waddr   (prod_waddr),
    .prod_wdata   (mac_acc),
    .prod_raddr   (prod_raddr),
    .prod_rdata   (prod_rdata)
  );

  // first pass multiplies the base matrix by itself
  assign mac_a             = (pass == '0) ? base_rdata_a : prod_rdata;
  assign mac_ctl.mul_en    = (state == S_MMUL);
  assign mac_ctl.acc_en    = (state == S_MACC);
  assign mac_ctl.acc_first = (k == '0);

  mp_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (base_rdata_b),
    .acc (mac_acc)
  );

  // emitted element: identity, loaded matrix, or last product bank
  always_comb begin
    priority if (power == '0) begin
      emit_value = (i == j) ? Q_ONE : '0;
    end else if (power == EXP_W'(1)) begin
      emit_value = base_rdata_a;
    end else begin
      emit_value = prod_rdata;
    end
  end

  assign out_load = (state == S_ELD) && (!out_valid || m_tready);

  // sequencer
  always_comb begin
    state_next = state;
    power_next = power;
    pass_next  = pass;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        if (in_beat && (s_tuser == MODE_RUN)) begin
          power_next = in_exp;
          pass_next  = '0;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = (in_exp > EXP_W'(1)) ? S_MRD : S_ERD;
        end
      end
      S_MRD: begin
        state_next = S_MMUL;
      end
      S_MMUL: begin
        state_next = S_MACC;
      end
      S_MACC: begin
        if (k == IDX_LAST) begin
          state_next = S_MWR;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = S_MRD;
        end
      end
      S_MWR: begin
        k_next = '0;
        if (elem_last) begin
          i_next    = '0;
          j_next    = '0;
          pass_next = pass + EXP_W'(1);
          state_next = ((pass + EXP_W'(1)) == power_m1) ? S_ERD : S_MRD;
        end else if (j == IDX_LAST) begin
          j_next     = '0;
          i_next     = i + IDX_W'(1);
          state_next = S_MRD;
        end else begin
          j_next     = j + IDX_W'(1);
          state_next = S_MRD;
        end
      end
      S_ERD: begin
        state_next = S_ELD;
      end
      S_ELD: begin
        if (out_load) begin
          if (elem_last) begin
            i_next     = '0;
            j_next     = '0;
            state_next = S_IDLE;
          end else if (j == IDX_LAST) begin
            j_next     = '0;
            i_next     = i + IDX_W'(1);
            state_next = S_ERD;
          end else begin
            j_next     = j + IDX_W'(1);
            state_next = S_ERD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      power <= '0;
      pass  <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      power <= power_next;
      pass  <= pass_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row   <= IDX_PORT_W'(i);
      out_col   <= IDX_PORT_W'(j);
      out_value <= emit_value;
      out_last  <= elem_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_value, out_col, out_row};
  assign m_tlast  = out_last;

  // checks
  `MP_ASSERT_NEXT(a_run_leaves_idle, in_beat && (s_tuser == MODE_RUN), state != S_IDLE, "run beat did not start the sequencer")
  `MP_ASSERT_IMPL(a_pass_in_range, state == S_MRD, pass < power_m1, "multiply pass beyond exponent")
  `MP_ASSERT_NEXT(a_emit_holds, (state == S_ELD) && !out_load, $stable(i) && $stable(j) && (state == S_ELD), "emission advanced while output stalled")

endmodule

### hdl/mp_mac.sv
// ----------------------------------------------------------------------------
// mp_mac
// shared q2.30 multiply-accumulate unit: registered product, rounded and
// saturated accumulation
// ----------------------------------------------------------------------------
module mp_mac (
  input  logic                               clk,
  input  mp_pkg::mac_ctl_t                   ctl,
  input  logic signed [mp_pkg::DATA_W-1:0]   a,
  input  logic signed [mp_pkg::DATA_W-1:0]   b,
  output logic signed [mp_pkg::DATA_W-1:0]   acc
);
  import mp_pkg::*;

  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] prod_rnd;
  logic signed [DATA_W+1:0]   rounded;
  logic signed [DATA_W-1:0]   acc_base;
  logic signed [DATA_W+2:0]   sum;
  logic signed [DATA_W-1:0]   acc_next;

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
  end

  // round to nearest q2.30, ties up, then add and saturate
  always_comb begin
    prod_rnd = prod + 64'sd536870912;
    rounded  = prod_rnd[2*DATA_W-1:DATA_W-2];
    acc_base = ctl.acc_first ? '0 : acc;
    sum      = (DATA_W+3)'(acc_base) + (DATA_W+3)'(rounded);
    if (sum > 35'sd2147483647) begin
      acc_next = SAT_MAX;
    end else if (sum < -35'sd2147483648) begin
      acc_next = SAT_MIN;
    end else begin
      acc_next = sum[DATA_W-1:0];
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      acc <= acc_next;
    end
  end

endmodule

### hdl/mp_store.sv
// ----------------------------------------------------------------------------
// mp_store
// base matrix memory (two read ports) and two-bank product memory
// ----------------------------------------------------------------------------
module mp_store #(
  parameter int MATRIX_SIZE = mp_pkg::DEF_MATRIX_SIZE,
  localparam int ADDR_W     = $clog2(MATRIX_SIZE * MATRIX_SIZE)
) (
  input  logic                              clk,
  input  logic                              base_we,
  input  logic [ADDR_W-1:0]                 base_waddr,
  input  logic signed [mp_pkg::DATA_W-1:0]  base_wdata,
  input  logic [ADDR_W-1:0]                 base_raddr_a,
  input  logic [ADDR_W-1:0]                 base_raddr_b,
  output logic signed [mp_pkg::DATA_W-1:0]  base_rdata_a,
  output logic signed [mp_pkg::DATA_W-1:0]  base_rdata_b,
  input  logic                              prod_we,
  input  logic [ADDR_W:0]                   prod_waddr,
  input  logic signed [mp_pkg::DATA_W-1:0]  prod_wdata,
  input  logic [ADDR_W:0]                   prod_raddr,
  output logic signed [mp_pkg::DATA_W-1:0]  prod_rdata
);
  import mp_pkg::*;

  logic signed [DATA_W-1:0] base_mem [MATRIX_SIZE*MATRIX_SIZE];
  logic signed [DATA_W-1:0] prod_mem [2**(ADDR_W+1)];

  // base matrix, written by load beats
  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[base_waddr] <= base_wdata;
    end
    base_rdata_a <= base_mem[base_raddr_a];
    base_rdata_b <= base_mem[base_raddr_b];
  end

  // product banks, bank select in the top address bit
  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_waddr] <= prod_wdata;
    end
    prod_rdata <= prod_mem[prod_raddr];
  end

endmodule
